// ===== hdl/sltd_pkg.sv =====
// ----------------------------------------------------------------------------
// sltd_pkg
// Types and constants shared by the sync/length/trailer deframer.
// ----------------------------------------------------------------------------
package sltd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PIDX_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd70;
  localparam logic [BYTE_W-1:0] END_RESET  = 8'd69;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_VALUE = 2'd0,
    REG_END_VALUE  = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
  } res_t;

endpackage

// ===== hdl/sltd_if.sv =====
// ----------------------------------------------------------------------------
// sltd channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface sltd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sltd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_data;
  logic       frame_first;
  logic       payload_last;
  modport source (output valid, output out_kind, output out_data,
                  output frame_first, output payload_last, input ready);
  modport sink   (input valid, input out_kind, input out_data,
                  input frame_first, input payload_last, output ready);
endinterface

interface sltd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] idx;
  logic [7:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== hdl/sltd_fsm.sv =====
// ----------------------------------------------------------------------------
// sltd_fsm
// Per-byte frame state machine: sync hunt, payload pass, trailer check.
// ----------------------------------------------------------------------------
module sltd_fsm #(
  parameter int unsigned SYNC_LEN     = 5,
  parameter int unsigned END_LEN      = 5,
  parameter int unsigned HEADER_EXTRA = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            sync_value,
  input  logic [7:0]            end_value,
  output logic                  res_valid,
  output sltd_pkg::res_t        res
);
  import sltd_pkg::*;

  localparam int unsigned MAX_LEN = (SYNC_LEN > END_LEN) ? SYNC_LEN : END_LEN;
  localparam int unsigned MC_W    = $clog2(MAX_LEN + 1);
  localparam logic [PIDX_W-1:0] HDR_LAST = PIDX_W'(HEADER_EXTRA - 1);
  localparam logic [PIDX_W-1:0] HDR_ADD  = PIDX_W'(HEADER_EXTRA);
  localparam logic [MC_W-1:0]   SYNC_N   = MC_W'(SYNC_LEN);
  localparam logic [MC_W-1:0]   END_N    = MC_W'(END_LEN);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [MC_W-1:0]     mc_r, mc_nxt, mc_inc;
  logic [PIDX_W-1:0]   pidx_r, pidx_nxt;
  logic [PIDX_W-1:0]   ptot_r, ptot_nxt, tot_w;
  logic                ok_r, ok_nxt, ok_w;

  always_comb begin
    phase_nxt = phase_r;
    mc_nxt    = mc_r;
    pidx_nxt  = pidx_r;
    ptot_nxt  = ptot_r;
    ok_nxt    = ok_r;
    res_valid = 1'b0;
    res.kind  = KIND_PAYLOAD;
    res.data  = '0;
    res.first = 1'b0;
    res.last  = 1'b0;
    mc_inc    = mc_r + 1'b1;
    ok_w      = ok_r & (rx_byte == end_value);
    tot_w     = (pidx_r == HDR_LAST) ? (PIDX_W'(rx_byte) + HDR_ADD) : ptot_r;
    unique case (phase_r)
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.data  = rx_byte;
        res.first = (pidx_r == '0);
        res.last  = (pidx_r >= HDR_LAST) &&
                    (({1'b0, pidx_r} + 1'b1) >= {1'b0, tot_w});
        ptot_nxt  = tot_w;
        if (res.last) begin
          phase_nxt = PH_TRAILER;
          mc_nxt    = '0;
          ok_nxt    = 1'b1;
          pidx_nxt  = '0;
        end else begin
          pidx_nxt = pidx_r + 1'b1;
        end
      end
      PH_TRAILER: begin
        if (mc_inc >= END_N) begin
          res_valid = 1'b1;
          res.kind  = ok_w ? KIND_GOOD : KIND_BAD;
          phase_nxt = PH_HUNT;
          mc_nxt    = '0;
          ok_nxt    = 1'b1;
          pidx_nxt  = '0;
          ptot_nxt  = '0;
        end else begin
          mc_nxt = mc_inc;
          ok_nxt = ok_w;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == sync_value) begin
          if (mc_inc >= SYNC_N) begin
            phase_nxt = PH_PAYLOAD;
            mc_nxt    = '0;
            pidx_nxt  = '0;
            ptot_nxt  = '0;
          end else begin
            mc_nxt = mc_inc;
          end
        end else begin
          mc_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      mc_r    <= '0;
      pidx_r  <= '0;
      ptot_r  <= '0;
      ok_r    <= 1'b1;
    end else if (acc) begin
      phase_r <= phase_nxt;
      mc_r    <= mc_nxt;
      pidx_r  <= pidx_nxt;
      ptot_r  <= ptot_nxt;
      ok_r    <= ok_nxt;
    end
  end

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_valid && res.kind != KIND_PAYLOAD) |->
      (res.data == '0 && !res.first && !res.last))
    else $error("end request carries payload bits");

  a_trailer_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TRAILER) |-> (pidx_r == '0))
    else $error("payload index not cleared in trailer");

  a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HUNT) |-> (mc_r < SYNC_N))
    else $error("sync count reached limit while hunting");

endmodule

// ===== hdl/sltd_outq.sv =====
// ----------------------------------------------------------------------------
// sltd_outq
// Two-entry result queue; decouples the byte input from result stalls.
// ----------------------------------------------------------------------------
module sltd_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sltd_pkg::res_t push_res,
  output logic           can_take,
  output logic           out_valid,
  input  logic           out_ready,
  output sltd_pkg::res_t head
);
  import sltd_pkg::*;

  res_t       head_r, head_nxt;
  res_t       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign can_take  = (cnt_r != 2'd2);
  assign head      = head_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    priority case (1'b1)
      push && pop: begin
        if (cnt_r == 2'd1) begin
          head_nxt = push_res;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_res;
        end
      end
      push: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd0) begin
          head_nxt = push_res;
        end else begin
          tail_nxt = push_res;
        end
      end
      pop: begin
        cnt_nxt  = cnt_r - 2'd1;
        head_nxt = tail_r;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && cnt_r == 2'd2))
    else $error("push into full result queue");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("result queue count wrong after pop");

endmodule

// ===== hdl/sync_length_trailer_deframer_core.sv =====
// ----------------------------------------------------------------------------
// sync_length_trailer_deframer_core
// Byte-stream deframer: sync run, length-coded payload, checked trailer.
// ----------------------------------------------------------------------------
// in_ch : one received byte per request (valid/ready).
// out_ch: zero or one result per byte: payload byte (kind 0, with first and
//         last flags), or an end result after the last trailer byte, kind 1
//         for a good trailer and kind 2 for a bad one.
// cfg_ch: register writes, index 0 sync byte, index 1 end byte; always ready.
//         Write only while no frame is in flight.
// Throughput: one byte per cycle while the result queue has room. The frame
// state updates at the accepting edge, where the byte's result enters the queue.
// A two-entry result queue sits in front of out_ch: in_ch stays ready while
// the queue has room, so a stalled receiver blocks input only after two
// results are waiting.
// Reset (rst_n low, synchronous): hunting for sync, queue empty, registers
// back to 'F' and 'E'.
// ----------------------------------------------------------------------------
module sync_length_trailer_deframer_core #(
  parameter int unsigned SYNC_LEN     = 5,
  parameter int unsigned END_LEN      = 5,
  parameter int unsigned HEADER_EXTRA = 3
) (
  input logic         clk,
  input logic         rst_n,
  sltd_byte_if.sink   in_ch,
  sltd_res_if.source  out_ch,
  sltd_cfg_if.sink    cfg_ch
);
  import sltd_pkg::*;

  logic [BYTE_W-1:0] sync_value_r;
  logic [BYTE_W-1:0] end_value_r;
  logic              acc;
  logic              can_take;
  logic              res_valid;
  res_t              res;
  res_t              head;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = can_take;
  assign acc          = in_ch.valid && can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= SYNC_RESET;
      end_value_r  <= END_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        REG_SYNC_VALUE: sync_value_r <= cfg_ch.data;
        REG_END_VALUE:  end_value_r  <= cfg_ch.data;
        default: begin
          sync_value_r <= sync_value_r;
        end
      endcase
    end
  end

  sltd_fsm #(
    .SYNC_LEN     (SYNC_LEN),
    .END_LEN      (END_LEN),
    .HEADER_EXTRA (HEADER_EXTRA)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .rx_byte    (in_ch.rx_byte),
    .sync_value (sync_value_r),
    .end_value  (end_value_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  sltd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_valid),
    .push_res  (res),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .head      (head)
  );

  assign out_ch.out_kind     = head.kind;
  assign out_ch.out_data     = head.data;
  assign out_ch.frame_first  = head.first;
  assign out_ch.payload_last = head.last;

endmodule

// ===== bench/sync_length_trailer_deframer_core_test.sv =====
// ----------------------------------------------------------------------------
// sync_length_trailer_deframer_core_test
// Self-checking bench for the sync/length/trailer deframer. Byte streams of
// well-formed frames, broken sync runs, bad trailers and noise are sent in
// random bursts while the result side stalls on its own pattern. A frame
// tracker predicts every result, and each received result is checked
// against it. The sync and end bytes are changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_length_trailer_deframer_core_test;
  import sltd_pkg::*;

  localparam int SYNC_CNT       = 5;
  localparam int END_CNT        = 5;
  localparam int HDR_EXTRA      = 3;
  localparam int PHASE_ITEMS    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {PH_HUNT, PH_PAYLOAD, PH_TRAILER} frame_phase_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  class deframe_board;
    logic [7:0]   sync_byte;
    logic [7:0]   end_byte;
    frame_phase_t cur_phase;
    logic [2:0]   mark_cnt;
    logic [8:0]   pay_idx;
    logic [8:0]   pay_total;
    bit           trail_ok;
    res_t         pending_results[$];
    int           err_count;

    function new();
      sync_byte = SYNC_RESET;
      end_byte  = END_RESET;
      cur_phase = PH_HUNT;
      mark_cnt  = '0;
      pay_idx   = '0;
      pay_total = '0;
      trail_ok  = 1'b1;
      err_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_SYNC_VALUE: sync_byte = val;
        REG_END_VALUE:  end_byte  = val;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      res_t r;
      r = '0;
      case (cur_phase)
        PH_PAYLOAD: begin
          r.kind  = KIND_PAYLOAD;
          r.data  = b;
          r.first = (pay_idx == 0);
          if (pay_idx == HDR_EXTRA - 1) pay_total = 9'(b + HDR_EXTRA);
          if (pay_idx >= HDR_EXTRA - 1 && pay_idx + 1 >= pay_total) r.last = 1'b1;
          pending_results.push_back(r);
          if (r.last) begin
            cur_phase = PH_TRAILER;
            mark_cnt  = '0;
            trail_ok  = 1'b1;
            pay_idx   = '0;
          end else begin
            pay_idx = pay_idx + 9'd1;
          end
        end
        PH_TRAILER: begin
          if (b != end_byte) trail_ok = 1'b0;
          mark_cnt = mark_cnt + 3'd1;
          if (mark_cnt >= END_CNT) begin
            r.kind = trail_ok ? KIND_GOOD : KIND_BAD;
            pending_results.push_back(r);
            cur_phase = PH_HUNT;
            mark_cnt  = '0;
            trail_ok  = 1'b1;
            pay_idx   = '0;
            pay_total = '0;
          end
        end
        default: begin
          cur_phase = PH_HUNT;
          if (b == sync_byte) begin
            mark_cnt = mark_cnt + 3'd1;
            if (mark_cnt >= SYNC_CNT) begin
              cur_phase = PH_PAYLOAD;
              mark_cnt  = '0;
              pay_idx   = '0;
              pay_total = '0;
            end
          end else begin
            mark_cnt = '0;
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic first_f,
                               logic last_f);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0d", kind, data);
        err_count++;
        return;
      end
      want = pending_results.pop_front();
      if (want.kind !== kind) begin
        $error("out_kind: expected %0d, actual %0d", want.kind, kind);
        err_count++;
      end
      if (want.data !== data) begin
        $error("out_data: expected %0d, actual %0d", want.data, data);
        err_count++;
      end
      if (want.first !== first_f) begin
        $error("frame_first: expected %0d, actual %0d", want.first, first_f);
        err_count++;
      end
      if (want.last !== last_f) begin
        $error("payload_last: expected %0d, actual %0d", want.last, last_f);
        err_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sltd_byte_if in_ch();
  sltd_res_if  out_ch();
  sltd_cfg_if  cfg_ch();

  sync_length_trailer_deframer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  deframe_board board;
  logic [7:0]   cur_sync = SYNC_RESET;
  logic [7:0]   cur_end  = END_RESET;
  int           burst_left = 0;
  int           sent_count = 0;
  int           idle_cycles = 0;
  rx_mode_t     rx_mode = RX_OPEN;
  int           rx_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side stall pattern
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(5, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default:   out_ch.ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_byte(in_ch.rx_byte);
      if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_ch.idx, cfg_ch.data);
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.out_kind, out_ch.out_data, out_ch.frame_first,
                           out_ch.payload_last);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("sync_length_trailer_deframer_core_test NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] v);
    return v ^ 8'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end else begin
      burst_left--;
    end
  endtask

  // wait until every predicted result has come back, plus the pipeline
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_SYNC_VALUE) cur_sync = val;
    if (idx == REG_END_VALUE) cur_end = val;
    @(posedge clk);
  endtask

  // sync run, topic high/low, length, body, trailer
  task automatic send_frame(input int len, input bit bad_trail, input bit sync_topic);
    int i;
    int bad_pos;
    int pick;
    bad_pos = bad_trail ? $urandom_range(0, END_CNT - 1) : -1;
    repeat (SYNC_CNT) send_byte(cur_sync);
    send_byte(sync_topic ? cur_sync : any_byte());
    send_byte(any_byte());
    send_byte(8'(len));
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 7);
      send_byte(pick == 0 ? cur_sync : (pick == 1 ? cur_end : any_byte()));
    end
    for (i = 0; i < END_CNT; i++) begin
      if (i == bad_pos || (bad_trail && $urandom_range(0, 3) == 0))
        send_byte(other_than(cur_end));
      else
        send_byte(cur_end);
    end
  endtask

  // short sync run cut off by a non-sync byte
  task automatic send_broken_sync(input int k);
    repeat (k) send_byte(cur_sync);
    send_byte(other_than(cur_sync));
  endtask

  // at most four bytes, then a non-sync byte, so no frame starts here
  task automatic send_noise(input int n);
    repeat (n) send_byte($urandom_range(0, 2) == 0 ? cur_sync : any_byte());
    send_byte(other_than(cur_sync));
  endtask

  initial begin
    int p;
    int goal;
    int len;
    board = new();
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.rx_byte  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.idx     <= REG_SYNC_VALUE;
    cfg_ch.data    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_broken_sync(SYNC_CNT - 1);
    send_broken_sync(1);
    repeat (SYNC_CNT) send_byte(cur_sync);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'd1);
    send_byte(8'hFF);
    repeat (END_CNT) send_byte(cur_end);
    send_frame(0, 1'b0, 1'b0);
    send_frame(2, 1'b1, 1'b1);
    send_frame(0, 1'b1, 1'b0);
    settle();
    write_cfg(REG_SPARE_2, any_byte());
    write_cfg(REG_SPARE_3, any_byte());
    send_frame(1, 1'b0, 1'b0);

    for (p = 0; p < 4; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: begin
            write_cfg(REG_SYNC_VALUE, 8'h00);
            write_cfg(REG_END_VALUE, 8'hFF);
          end
          2: begin
            write_cfg(REG_SYNC_VALUE, 8'hFF);
            write_cfg(REG_END_VALUE, 8'h00);
          end
          default: begin
            write_cfg(REG_SYNC_VALUE, any_byte());
            write_cfg(REG_END_VALUE, any_byte());
            write_cfg(REG_SPARE_3, any_byte());
          end
        endcase
      end
      goal = sent_count + PHASE_ITEMS;
      while (sent_count < goal) begin
        case ($urandom_range(0, 9))
          0: send_noise($urandom_range(0, 4));
          1: send_broken_sync($urandom_range(1, SYNC_CNT - 1));
          default: begin
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 255)
                                               : $urandom_range(0, 12);
            send_frame(len, $urandom_range(0, 4) == 0, $urandom_range(0, 7) == 0);
          end
        endcase
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (board.err_count == 0)
      $display("sync_length_trailer_deframer_core_test OK");
    else
      $display("sync_length_trailer_deframer_core_test NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sltd_pkg.sv
hdl/sltd_if.sv
hdl/sltd_fsm.sv
hdl/sltd_outq.sv
hdl/sync_length_trailer_deframer_core.sv
bench/sync_length_trailer_deframer_core_test.sv
